[hdl/mfbb_pkg.sv]
`default_nettype none

package mfbb_pkg;

    // Field widths
    localparam int POS_W      = 16;
    localparam int CNT_W      = 6;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 13;
    localparam int BYTE_IDX_W = POS_W - 3;
    localparam int DIDX_W     = $clog2(DATA_W);

    // Largest access in bits
    localparam int MAX_COUNT = 32;

    // Default store size in bytes
    localparam int DEF_BUFFER_BYTES = 4096;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_SEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH,
        ST_SHIFT,
        ST_STORE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [CNT_W-1:0]  bit_count;
        logic [DATA_W-1:0] write_data;
        logic [POS_W-1:0]  new_position;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  bits_read;
        logic [POS_W-1:0]  position;
    } out_item_t;

endpackage

`default_nettype wire

[hdl/mfbb_store.sv]
`default_nettype none

module mfbb_store #(
    parameter int DEPTH = mfbb_pkg::DEF_BUFFER_BYTES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);
    import mfbb_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // single port byte array, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/msb_first_bit_buffer.sv]
// Bit buffer: one item at a time. A read fetches each byte under the pointer and
// shifts its bits out; a write also stores back each byte inside the limit;
// set pointer goes straight to the result; clear zeroes bytes_in_use bytes.
// Bits pass one at a time through the shift stage; each byte takes one fetch (and one
// write back for writes) on the single byte-wide store port.
// rst_n is asynchronous, active low: after release the store is zeroed by a
// pass over all BUFFER_BYTES addresses during which in_stall stays high.
`default_nettype none

module msb_first_bit_buffer #(
    parameter int BUFFER_BYTES = mfbb_pkg::DEF_BUFFER_BYTES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire mfbb_pkg::in_item_t            in_item,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output mfbb_pkg::out_item_t                out_item,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mfbb_pkg::CFG_W-1:0]    cfg_data
);
    import mfbb_pkg::*;

    localparam int AW    = $clog2(BUFFER_BYTES);
    localparam int LIM_W = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        got_reg, got_next;
    logic [DATA_W-1:0]       rdata_reg, rdata_next;
    logic [DATA_W-1:0]       wdata_reg, wdata_next;
    logic [7:0]              mask_reg, mask_next;
    logic [BYTE_IDX_W-1:0]   byte_reg, byte_next;
    logic                    inr_reg, inr_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic [LIM_W-1:0]        limit_reg, limit_next;
    out_item_t               out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_addr;
    logic [7:0]              mem_wdata, mem_q;
    logic [CNT_W-1:0]        cnt_sat;
    logic [BYTE_IDX_W-1:0]   pos_byte;
    logic [2:0]              bit_sel;
    logic                    in_range;
    logic                    last_bit;
    logic                    byte_end;

    mfbb_store #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_q)
    );

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            pos_reg       <= '0;
            clr_reg       <= '0;
            limit_reg     <= LIM_W'(BUFFER_BYTES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            clr_reg       <= clr_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        rem_reg   <= rem_next;
        got_reg   <= got_next;
        rdata_reg <= rdata_next;
        wdata_reg <= wdata_next;
        mask_reg  <= mask_next;
        byte_reg  <= byte_next;
        inr_reg   <= inr_next;
        out_reg   <= out_next;
    end

    // helpers
    assign cnt_sat  = (in_item.bit_count > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT)
                                                              : in_item.bit_count;
    assign pos_byte = pos_reg[POS_W-1:3];
    assign bit_sel  = ~pos_reg[2:0];
    assign in_range = CMP_W'(pos_byte) < CMP_W'(limit_reg);
    assign last_bit = (rem_reg == CNT_W'(1));
    assign byte_end = (pos_reg[2:0] == 3'b111);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        got_next       = got_reg;
        rdata_next     = rdata_reg;
        wdata_next     = wdata_reg;
        mask_next      = mask_reg;
        byte_next      = byte_reg;
        inr_next       = inr_reg;
        clr_next       = clr_reg;
        limit_next     = limit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = AW'(byte_reg);
        mem_wdata      = mem_q | mask_reg;

        // byte limit, held to the store size
        if (cfg_valid)
        begin
            limit_next = (CMP_W'(cfg_data) > CMP_W'(BUFFER_BYTES)) ? LIM_W'(BUFFER_BYTES)
                                                                  : LIM_W'(cfg_data);
        end

        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = 8'h00;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(BUFFER_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_item.op;
                    rem_next   = cnt_sat;
                    got_next   = '0;
                    rdata_next = '0;
                    wdata_next = in_item.write_data;
                    case (in_item.op)
                        OP_READ, OP_WRITE:
                        begin
                            state_next = (cnt_sat == '0) ? ST_FINISH : ST_FETCH;
                        end
                        OP_SEEK:
                        begin
                            pos_next   = in_item.new_position;
                            state_next = ST_FINISH;
                        end
                        default:
                        begin
                            pos_next   = '0;
                            clr_next   = '0;
                            state_next = (limit_reg == '0) ? ST_FINISH : ST_CLEAR;
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = 8'h00;
                clr_next  = clr_reg + AW'(1);
                if ((CMP_W'(clr_reg) + CMP_W'(1)) == CMP_W'(limit_reg))
                begin
                    state_next = ST_FINISH;
                end
            end

            // read the byte under the pointer
            ST_FETCH:
            begin
                mem_re    = 1'b1;
                mem_addr  = AW'(pos_byte);
                byte_next = pos_byte;
                inr_next  = in_range;
                mask_next = '0;
                if (op_reg == OP_READ && !in_range)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end

            // one bit per cycle
            ST_SHIFT:
            begin
                if (op_reg == OP_READ)
                begin
                    rdata_next = {rdata_reg[DATA_W-2:0], mem_q[bit_sel]};
                    got_next   = got_reg + CNT_W'(1);
                end
                else
                begin
                    mask_next[bit_sel] = wdata_reg[DIDX_W'(rem_reg - CNT_W'(1))];
                end
                pos_next = pos_reg + POS_W'(1);
                rem_next = rem_reg - CNT_W'(1);
                if (last_bit || byte_end)
                begin
                    if (op_reg == OP_WRITE && inr_reg)
                    begin
                        state_next = ST_STORE;
                    end
                    else if (last_bit)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end

            // merge written bits into the byte
            ST_STORE:
            begin
                mem_we     = 1'b1;
                state_next = (rem_reg == '0) ? ST_FINISH : ST_FETCH;
            end

            // hand the result to the output register
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.read_data = rdata_reg;
                    out_next.bits_read = got_reg;
                    out_next.position  = pos_reg;
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

[hdl/mfbb_checker.sv]
`default_nettype none

module mfbb_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire mfbb_pkg::in_item_t   in_item,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire mfbb_pkg::out_item_t  out_item
);
    import mfbb_pkg::*;

    // a stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_item))
        else $error("input item changed while stalled");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    // read bits are right aligned and never more than an access
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.bits_read <= CNT_W'(MAX_COUNT)
                   && (out_item.read_data >> out_item.bits_read) == '0)
        else $error("read data wider than bit count");

endmodule

bind msb_first_bit_buffer mfbb_checker u_mfbb_checker (.*);

`default_nettype wire
